>>> sv/gkdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkdt_pkg
// Shared codes and fixed-point constants for the Gaussian kernel density block.
// ----------------------------------------------------------------------------
package gkdt_pkg;

   // Item kinds carried on the request tuser.
   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_CLEAR  = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   // Result status codes.
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_NOT_STORED = 2'd1;
   localparam logic [1:0] STAT_FULL       = 2'd2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_BANDWIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TORUS_ON  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_LOWER   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_X_UPPER   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_Y_LOWER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Y_UPPER   = 3'd5;

   // Normalization numerators: round(2^40/sqrt(2*pi)) and round(2^56/(2*pi)).
   localparam int NUM_W = 54;
   localparam logic [NUM_W-1:0] K_ONE_D = 54'd438641676113;
   localparam logic [NUM_W-1:0] K_TWO_D = 54'd11468322278445521;

   // Norm is capped at 2^48, the density saturates at 2^48-1.
   localparam int NORM_W = 49;
   localparam logic [NORM_W-1:0] NORM_CAP = 49'h1_0000_0000_0000;
   localparam logic [47:0] DENS_MAX = 48'hFFFF_FFFF_FFFF;

   // Exp table entries are Q1.30, at most 2^30.
   localparam int TAB_W = 31;

   // Squared-distance limit 32*b^2 fits in 53 bits.
   localparam int LIM_W = 53;

endpackage

>>> sv/gkdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkdt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gkdt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/gaussian_kernel_density_torus.sv
`timescale 1ns / 1ps
// Append, clear and unused kinds give their result in the cycle after acceptance. A query
// runs setup, a 54-bit serial divide for the norm, one point-memory read per stored point,
// then the kernel pipeline drain. The single read port of the point memory sets the rate.
// Reset clears the point count, the state and the handshakes and restores the
// configuration registers to their defaults; memory is not cleared.
// ----------------------------------------------------------------------------
// gaussian_kernel_density_torus
// Stores 2D points and returns the summed Gaussian kernel density at a stored point.
// ----------------------------------------------------------------------------
module gaussian_kernel_density_torus
   import gkdt_pkg::*;
#(
   parameter int MAX_POINTS      = 1024,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request stream.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [79:0]          req_tdata,  // pos_x[31:0], pos_y[63:32], query_index[73:64]
   input  logic [1:0]           req_tuser,  // mode[1:0]
   // Result stream.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,  // density[47:0], point_index[57:48], status[59:58]
   // Configuration writes.
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int CMPW = (CW > 10) ? CW : 10;
   localparam int KW   = $clog2(EXP_TABLE_DEPTH);
   localparam int QW   = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int NW   = LIM_W + QW;
   localparam int NV   = 10 + QW;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_NDIV  = 3'd3;
   localparam logic [2:0] ST_RUN   = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   typedef logic [TAB_W-1:0] exp_tab_type [EXP_TABLE_DEPTH];

   // Shift-and-subtract division for the table build at elaboration.
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-16*k/depth) in Q1.30 from a Taylor-series ratio and repeated products.
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type t;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] ratio;
      logic [63:0] prod;
      term = 64'd1 << 56;
      pos  = term;
      neg  = '0;
      for (int k = 1; k <= 40; k++) begin
         term = udiv64(term * 64'd16, 64'(EXP_TABLE_DEPTH) * 64'(k));
         if (k % 2 == 1) neg = neg + term;
         else            pos = pos + term;
      end
      ratio = (pos - neg + (64'd1 << 25)) >> 26;
      t[0] = TAB_W'(64'd1 << 30);
      for (int k = 1; k < EXP_TABLE_DEPTH; k++) begin
         prod = (64'(t[k-1]) * ratio + (64'd1 << 29)) >> 30;
         t[k] = prod[TAB_W-1:0];
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

   // Configuration registers.
   logic [23:0]        bw_ff;
   logic               torus_ff;
   logic signed [31:0] xlo_ff, xhi_ff, ylo_ff, yhi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff    <= 24'd65536;
         torus_ff <= 1'b0;
         xlo_ff   <= '0;
         xhi_ff   <= 32'sd3276800;
         ylo_ff   <= '0;
         yhi_ff   <= 32'sd3276800;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_BANDWIDTH: bw_ff    <= csr_wdata[23:0];
            REG_TORUS_ON:  torus_ff <= csr_wdata[0];
            REG_X_LOWER:   xlo_ff   <= csr_wdata;
            REG_X_UPPER:   xhi_ff   <= csr_wdata;
            REG_Y_LOWER:   ylo_ff   <= csr_wdata;
            REG_Y_UPPER:   yhi_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request fields.
   logic [1:0]  req_mode;
   logic [63:0] req_point;
   logic [9:0]  req_qi;
   assign req_mode  = req_tuser;
   assign req_point = req_tdata[63:0];
   assign req_qi    = req_tdata[73:64];

   // Control state.
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] j_ff, j_in;
   logic [AW-1:0] qidx_ff, qidx_in;
   logic [9:0]    qout_ff, qout_in;
   logic [5:0]    ndcnt_ff, ndcnt_in;
   logic [NV-1:0] vld_ff, vld_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [47:0]   rsp_dens_ff, rsp_dens_in;
   logic [9:0]    rsp_idx_ff, rsp_idx_in;
   logic [1:0]    rsp_stat_ff, rsp_stat_in;

   logic accept, out_free, q_bad, issue;
   logic          wr_en, rd_en;
   logic [AW-1:0] rd_addr;
   logic [63:0]   rd_data;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign q_bad      = CMPW'(req_qi) >= CMPW'(cnt_ff);

   // Per-query setup registers.
   logic [23:0]        beff;
   logic [47:0]        b2_ff;
   logic [LIM_W-1:0]   lim_ff, qs_ff;
   logic               big_ff;
   logic [31:0]        px_ff, py_ff;
   logic [NUM_W-1:0]   ndnum_ff;
   logic [47:0]        ndden_ff, ndrem_ff;
   logic [NUM_W-1:0]   ndquo_ff;
   logic [NORM_W-1:0]  norm_ff;
   logic [47:0]        acc_ff;
   logic signed [32:0] span_ff [2];

   logic [48:0]        nd_rs;
   logic               nd_ge;
   logic [48:0]        nd_rn;
   logic [LIM_W-1:0]   lim_c;
   logic [49:0]        acc_sum;

   assign beff  = (bw_ff == '0) ? 24'd1 : bw_ff;
   assign lim_c = {b2_ff, 5'b0};

   // One quotient bit of the norm divide per cycle.
   always_comb begin
      nd_rs = {ndrem_ff, ndnum_ff[NUM_W-1]};
      nd_ge = nd_rs >= {1'b0, ndden_ff};
      nd_rn = nd_ge ? (nd_rs - {1'b0, ndden_ff}) : nd_rs;
   end

   // Sequencer and result register.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      j_in         = j_ff;
      qidx_in      = qidx_ff;
      qout_in      = qout_ff;
      ndcnt_in     = ndcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dens_in  = rsp_dens_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_stat_in  = rsp_stat_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = j_ff[AW-1:0];
      issue        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_dens_in  = '0;
               rsp_idx_in   = '0;
               rsp_stat_in  = STAT_OK;
               unique case (req_mode)
                  MODE_APPEND: begin
                     if (cnt_ff == CW'(MAX_POINTS)) begin
                        rsp_stat_in = STAT_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        rsp_idx_in = 10'(cnt_ff);
                        cnt_in     = cnt_ff + 1'b1;
                     end
                  end
                  MODE_CLEAR: begin
                     cnt_in = '0;
                  end
                  MODE_QUERY: begin
                     rsp_idx_in = req_qi;
                     if (q_bad) begin
                        rsp_stat_in = STAT_NOT_STORED;
                     end else begin
                        rsp_valid_in = 1'b0;
                        qidx_in      = AW'(req_qi);
                        qout_in      = req_qi;
                        state_in     = ST_SETUP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            rd_en    = 1'b1;
            rd_addr  = qidx_ff;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            ndcnt_in = '0;
            state_in = ST_NDIV;
         end
         ST_NDIV: begin
            ndcnt_in = ndcnt_ff + 1'b1;
            if (ndcnt_ff == 6'(NUM_W - 1)) begin
               j_in     = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            rd_en = 1'b1;
            issue = 1'b1;
            j_in  = j_ff + 1'b1;
            if (j_in == cnt_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (vld_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dens_in  = acc_ff;
               rsp_idx_in   = qout_ff;
               rsp_stat_in  = STAT_OK;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign vld_in = {vld_ff[NV-2:0], issue};

   // Payload and per-query registers.
   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      qidx_ff     <= qidx_in;
      qout_ff     <= qout_in;
      ndcnt_ff    <= ndcnt_in;
      rsp_dens_ff <= rsp_dens_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_stat_ff <= rsp_stat_in;
      b2_ff       <= beff * beff;
      span_ff[0]  <= 33'(xhi_ff) - 33'(xlo_ff);
      span_ff[1]  <= 33'(yhi_ff) - 33'(ylo_ff);
      norm_ff     <= (ndquo_ff > NUM_W'(NORM_CAP)) ? NORM_CAP : ndquo_ff[NORM_W-1:0];
      if (state_ff == ST_LOAD) begin
         px_ff    <= rd_data[31:0];
         py_ff    <= rd_data[63:32];
         lim_ff   <= lim_c;
         big_ff   <= |lim_c[LIM_W-1:40];
         qs_ff    <= (|lim_c[LIM_W-1:40]) ? (lim_c >> 13) : lim_c;
         ndnum_ff <= (ylo_ff == yhi_ff) ? K_ONE_D : K_TWO_D;
         ndden_ff <= (ylo_ff == yhi_ff) ? 48'(beff) : b2_ff;
         ndrem_ff <= '0;
         ndquo_ff <= '0;
         acc_ff   <= '0;
      end else if (state_ff == ST_NDIV) begin
         ndnum_ff <= {ndnum_ff[NUM_W-2:0], 1'b0};
         ndrem_ff <= nd_rn[47:0];
         ndquo_ff <= {ndquo_ff[NUM_W-2:0], nd_ge};
      end else if (vld_ff[NV-1]) begin
         acc_ff <= (acc_sum > 50'(DENS_MAX)) ? DENS_MAX : acc_sum[47:0];
      end
   end

   // Point memory: x in the low half, y in the high half.
   gkdt_ram #(
      .WIDTH (64),
      .DEPTH (MAX_POINTS)
   ) u_points (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_point),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Kernel pipeline, one lane per axis up to the squared distance.
   logic [32:0]        g1_ff   [2];
   logic signed [34:0] wsel_ff [2];
   logic [31:0]        gap_ff  [2];
   logic [63:0]        sq_ff   [2];
   logic [63:0]        d2_ff;
   logic [32:0]        g1_c    [2];
   logic signed [34:0] wsel_c  [2];
   logic [31:0]        gap_c   [2];
   logic signed [32:0] dd;
   logic signed [34:0] sp35, g35, ww, aa;
   logic               wrap;
   logic [31:0]        coord_a [2];
   logic [31:0]        coord_b [2];

   assign coord_a[0] = rd_data[31:0];
   assign coord_a[1] = rd_data[63:32];
   assign coord_b[0] = px_ff;
   assign coord_b[1] = py_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         // Absolute difference.
         dd      = $signed({coord_a[a][31], coord_a[a]}) - $signed({coord_b[a][31], coord_b[a]});
         g1_c[a] = dd[32] ? 33'(-dd) : 33'(dd);
         // Wrap to the short way around when the torus is on.
         sp35      = 35'(span_ff[a]);
         g35       = $signed({2'b0, g1_ff[a]});
         wrap      = torus_ff && ($signed({1'b0, g1_ff[a], 1'b0}) > sp35);
         ww        = sp35 - g35;
         wsel_c[a] = wrap ? ww : g35;
         // Magnitude, capped at 2^31.
         aa       = wsel_ff[a][34] ? -wsel_ff[a] : wsel_ff[a];
         gap_c[a] = (aa > 35'sh0_8000_0000) ? 32'h8000_0000 : aa[31:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         g1_ff[a]   <= g1_c[a];
         wsel_ff[a] <= wsel_c[a];
         gap_ff[a]  <= gap_c[a];
         sq_ff[a]   <= 64'(gap_ff[a]) * 64'(gap_ff[a]);
      end
      d2_ff <= sq_ff[0] + sq_ff[1];
   end

   // Index divide: one quotient bit per stage.
   logic [NW-1:0]    drem_ff  [QW+1];
   logic [LIM_W-1:0] dden_ff  [QW+1];
   logic [QW-1:0]    dquo_ff  [QW+1];
   logic             dlive_ff [QW+1];
   logic [NW-1:0]    drem_c   [QW+1];
   logic [QW-1:0]    dquo_c   [QW+1];
   logic [NW-1:0]    dsh;
   logic [63:0]      ds;

   always_comb begin
      ds        = big_ff ? (d2_ff >> 13) : d2_ff;
      drem_c[0] = NW'(ds[LIM_W-1:0]) * NW'(EXP_TABLE_DEPTH);
      dquo_c[0] = '0;
      for (int i = 0; i < QW; i++) begin
         dsh = NW'(dden_ff[i]) << (QW - 1 - i);
         if (drem_ff[i] >= dsh) begin
            drem_c[i+1] = drem_ff[i] - dsh;
            dquo_c[i+1] = dquo_ff[i] | (QW'(1) << (QW - 1 - i));
         end else begin
            drem_c[i+1] = drem_ff[i];
            dquo_c[i+1] = dquo_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      drem_ff[0]  <= drem_c[0];
      dden_ff[0]  <= qs_ff;
      dquo_ff[0]  <= dquo_c[0];
      dlive_ff[0] <= d2_ff < 64'(lim_ff);
      for (int i = 0; i < QW; i++) begin
         drem_ff[i+1]  <= drem_c[i+1];
         dden_ff[i+1]  <= dden_ff[i];
         dquo_ff[i+1]  <= dquo_c[i+1];
         dlive_ff[i+1] <= dlive_ff[i];
      end
   end

   // Table lookup, scale by the norm, accumulate.
   logic [TAB_W-1:0] tval_ff;
   logic [55:0]      mhi_ff;
   logic [54:0]      mlo_ff;
   logic [48:0]      term_ff;
   logic             kin;
   logic [KW-1:0]    kidx;
   logic [79:0]      msum;

   always_comb begin
      kin  = dquo_ff[QW] < QW'(EXP_TABLE_DEPTH);
      kidx = kin ? dquo_ff[QW][KW-1:0] : '0;
      msum = {mhi_ff, 24'b0} + 80'(mlo_ff);
   end

   assign acc_sum = 50'(acc_ff) + 50'(term_ff);

   always_ff @(posedge clock) begin
      tval_ff <= (dlive_ff[QW] && kin) ? EXP_TAB[kidx] : '0;
      mhi_ff  <= 56'(tval_ff) * 56'(norm_ff[48:24]);
      mlo_ff  <= 55'(tval_ff) * 55'(norm_ff[23:0]);
      term_ff <= msum[78:30];
   end

   // Result port.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_stat_ff, rsp_idx_ff, rsp_dens_ff};

   // The point count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_POINTS))
      else $error("point count beyond store depth");

   // A query of a stored point starts the setup sequence.
   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_QUERY && !q_bad) |=> state_ff == ST_SETUP)
      else $error("query did not start");

   // The kernel pipeline only carries work while a query walks or drains.
   a_pipe_busy: assert property (@(posedge clock) disable iff (reset)
      (vld_ff != '0) |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("kernel pipeline active outside a query");

   // A finished query presents its result and returns to idle.
   a_fin_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("query result not presented");

endmodule
